// File: rtl/core/scc_pkg.sv
package scc_pkg;

    // Default geometry and fixed field widths.
    localparam int SLOT_COUNT_DEF = 64;
    localparam int MAX_WB         = 64;
    localparam int WBCNT_W        = $clog2(MAX_WB + 1);
    localparam int SLOT_W         = 6;
    localparam int SECTOR_W       = 32;
    localparam int ACTION_W       = 2;

    // Result action codes.
    localparam logic [ACTION_W-1:0] ACT_HIT       = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_FILL      = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_WRITEBACK = 2'd2;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_HIT,
        ST_VICTIM,
        ST_VCHECK,
        ST_VWB,
        ST_FILL,
        ST_FSCAN,
        ST_FGOT,
        ST_FLAST
    } t_state;

    // Source of the fields of an emitted result.
    typedef enum logic [1:0] {
        EM_HIT,
        EM_FILL,
        EM_VICTIM,
        EM_PEND
    } t_emit_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      load;
        logic      search;
        logic      set_hit;
        logic      set_free_slot;
        logic      victim_start;
        logic      victim_step;
        logic      victim_take;
        logic      rd_slot;
        logic      flush_step;
        logic      pend_load;
        logic      pend_clear;
        logic      hit_update;
        logic      fill;
        logic      wb_clean;
        logic      emit;
        t_emit_sel emit_sel;
        logic      last;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic req_flush;
        logic hit;
        logic search_done;
        logic full;
        logic acc_cur;
        logic dirty_cur;
        logic dirty_slot;
        logic scan_end;
        logic pend_valid;
        logic out_free;
    } t_dp_status;

endpackage

// File: rtl/core/sector_cache_second_chance.sv
// Directory of a fully associative sector cache with second-chance replacement.
// Input channel (i_valid / o_stall) carries one request: an access to
// i_sector (read or write by i_is_write) or, with i_req_type set, a flush.
// Output channel (o_valid / i_stall) carries results: hit, fill or writeback,
// each with a slot, a sector and o_last on the final result of a request.
// One request is worked on at a time; o_stall is high while it runs.
// The tag search reads the tag memory one slot per cycle; it ends at a hit or
// after the last filled slot. With all slots filled, a second-chance sweep from
// slot 0 clears the accessed flag of each slot it passes (up to SLOT_COUNT),
// takes the first slot found clear as the victim, checks it and writes it back if dirty.
// A flush walks the filled slots one per cycle, stopping at each dirty slot to
// write it back; a stalled receiver holds the walk at the next writeback.
// Results leave through an output register, so the next request can be taken
// while the final result of the previous one still waits.
// A stalled receiver holds the output register and pauses the work at the
// next result. Reset clears the fill count and the dirty and accessed flags;
// no request is taken in the cycle of reset and no clearing pass is needed.
module sector_cache_second_chance #(
    parameter int SLOT_COUNT = scc_pkg::SLOT_COUNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_req_type,
    input  logic [scc_pkg::SECTOR_W-1:0]  i_sector,
    input  logic                          i_is_write,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [scc_pkg::ACTION_W-1:0]  o_action,
    output logic [scc_pkg::SLOT_W-1:0]    o_slot,
    output logic [scc_pkg::SECTOR_W-1:0]  o_sector_out,
    output logic                          o_last
);

    scc_pkg::t_dp_cmd    cmd;
    scc_pkg::t_dp_status status;

    // Sequencer for search, victim sweep, fill and flush.
    scc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // Tag memory, slot flags and output register.
    scc_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_type   (i_req_type),
        .i_sector     (i_sector),
        .i_is_write   (i_is_write),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_action     (o_action),
        .o_slot       (o_slot),
        .o_sector_out (o_sector_out),
        .o_last       (o_last)
    );

endmodule

// File: rtl/core/scc_ctrl.sv
module scc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  scc_pkg::t_dp_status i_status,
    output scc_pkg::t_dp_cmd    o_cmd
);

    scc_pkg::t_state r_state;
    scc_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= scc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            scc_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = i_status.req_flush ? scc_pkg::ST_FSCAN : scc_pkg::ST_SEARCH;
                end
            end
            scc_pkg::ST_SEARCH: begin
                if (i_status.hit) begin
                    n_state = scc_pkg::ST_HIT;
                end else if (i_status.search_done) begin
                    n_state = i_status.full ? scc_pkg::ST_VICTIM : scc_pkg::ST_FILL;
                end
            end
            scc_pkg::ST_HIT: begin
                if (i_status.out_free) begin
                    n_state = scc_pkg::ST_IDLE;
                end
            end
            scc_pkg::ST_VICTIM: begin
                if (!i_status.acc_cur) begin
                    n_state = scc_pkg::ST_VCHECK;
                end
            end
            scc_pkg::ST_VCHECK: begin
                n_state = i_status.dirty_slot ? scc_pkg::ST_VWB : scc_pkg::ST_FILL;
            end
            scc_pkg::ST_VWB: begin
                if (i_status.out_free) begin
                    n_state = scc_pkg::ST_FILL;
                end
            end
            scc_pkg::ST_FILL: begin
                if (i_status.out_free) begin
                    n_state = scc_pkg::ST_IDLE;
                end
            end
            scc_pkg::ST_FSCAN: begin
                if (i_status.scan_end) begin
                    n_state = i_status.pend_valid ? scc_pkg::ST_FLAST : scc_pkg::ST_IDLE;
                end else if (i_status.dirty_cur) begin
                    n_state = scc_pkg::ST_FGOT;
                end
            end
            scc_pkg::ST_FGOT: begin
                if (!i_status.pend_valid || i_status.out_free) begin
                    n_state = scc_pkg::ST_FSCAN;
                end
            end
            scc_pkg::ST_FLAST: begin
                if (i_status.out_free) begin
                    n_state = scc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = scc_pkg::ST_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd          = '0;
        o_cmd.emit_sel = scc_pkg::EM_HIT;
        o_stall        = 1'b1;
        case (r_state)
            scc_pkg::ST_IDLE: begin
                // No item is taken while reset is held.
                o_stall    = !i_rst_n;
                o_cmd.load = i_valid && i_rst_n;
            end
            scc_pkg::ST_SEARCH: begin
                if (i_status.hit) begin
                    o_cmd.set_hit = 1'b1;
                end else begin
                    o_cmd.search = 1'b1;
                    if (i_status.search_done) begin
                        o_cmd.set_free_slot = !i_status.full;
                        o_cmd.victim_start  = i_status.full;
                    end
                end
            end
            scc_pkg::ST_HIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit       = 1'b1;
                    o_cmd.emit_sel   = scc_pkg::EM_HIT;
                    o_cmd.hit_update = 1'b1;
                end
            end
            scc_pkg::ST_VICTIM: begin
                if (i_status.acc_cur) begin
                    o_cmd.victim_step = 1'b1;
                end else begin
                    o_cmd.victim_take = 1'b1;
                end
            end
            scc_pkg::ST_VCHECK: begin
                o_cmd.rd_slot = 1'b1;
            end
            scc_pkg::ST_VWB: begin
                if (i_status.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = scc_pkg::EM_VICTIM;
                    o_cmd.wb_clean = 1'b1;
                end
            end
            scc_pkg::ST_FILL: begin
                if (i_status.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = scc_pkg::EM_FILL;
                    o_cmd.fill     = 1'b1;
                end
            end
            scc_pkg::ST_FSCAN: begin
                o_cmd.flush_step = !i_status.scan_end;
            end
            scc_pkg::ST_FGOT: begin
                if (!i_status.pend_valid) begin
                    o_cmd.pend_load = 1'b1;
                end else if (i_status.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_sel  = scc_pkg::EM_PEND;
                    o_cmd.pend_load = 1'b1;
                end
            end
            scc_pkg::ST_FLAST: begin
                if (i_status.out_free) begin
                    o_cmd.emit       = 1'b1;
                    o_cmd.emit_sel   = scc_pkg::EM_PEND;
                    o_cmd.last       = 1'b1;
                    o_cmd.pend_clear = 1'b1;
                end
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

endmodule

// File: rtl/core/scc_datapath.sv
module scc_datapath #(
    parameter int SLOT_COUNT = scc_pkg::SLOT_COUNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_type,
    input  logic [scc_pkg::SECTOR_W-1:0]  i_sector,
    input  logic                          i_is_write,
    input  scc_pkg::t_dp_cmd              i_cmd,
    output scc_pkg::t_dp_status           o_status,
    input  logic                          i_stall,
    output logic                          o_valid,
    output logic [scc_pkg::ACTION_W-1:0]  o_action,
    output logic [scc_pkg::SLOT_W-1:0]    o_slot,
    output logic [scc_pkg::SECTOR_W-1:0]  o_sector_out,
    output logic                          o_last
);

    localparam int IDX_W = $clog2(SLOT_COUNT);
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);

    // Request, scan and slot registers.
    logic [scc_pkg::SECTOR_W-1:0] r_sector;
    logic                         r_wr;
    logic [CNT_W-1:0]             r_used;
    logic [CNT_W-1:0]             r_idx;
    logic [IDX_W-1:0]             r_slot;
    logic [IDX_W-1:0]             r_q_idx;
    logic                         r_q_live;
    logic [scc_pkg::SECTOR_W-1:0] r_tag_q;
    logic [scc_pkg::WBCNT_W-1:0]  r_wbcnt;
    logic                         r_pend_valid;
    logic [IDX_W-1:0]             r_pend_slot;
    logic [scc_pkg::SECTOR_W-1:0] r_pend_tag;
    logic [SLOT_COUNT-1:0]        r_dirty;
    logic [SLOT_COUNT-1:0]        r_accessed;
    logic [scc_pkg::SECTOR_W-1:0] r_tag_mem [SLOT_COUNT];

    // Output register.
    logic                         r_out_valid;
    logic                         n_out_valid;
    logic [scc_pkg::ACTION_W-1:0] r_out_action;
    logic [IDX_W-1:0]             r_out_slot;
    logic [scc_pkg::SECTOR_W-1:0] r_out_sector;
    logic                         r_out_last;

    logic [IDX_W-1:0]             idx;
    logic                         idx_lt_used;
    logic                         full;
    logic                         dirty_cur;
    logic                         rd_en;
    logic [IDX_W-1:0]             rd_addr;
    logic                         out_free;
    logic [scc_pkg::ACTION_W-1:0] em_action;
    logic [IDX_W-1:0]             em_slot;
    logic [scc_pkg::SECTOR_W-1:0] em_sector;
    logic                         em_last;
    logic [scc_pkg::SLOT_W+IDX_W-1:0] slot_ext;

    assign idx         = r_idx[IDX_W-1:0];
    assign idx_lt_used = (r_idx < r_used);
    assign full        = (r_used == CNT_W'(SLOT_COUNT));
    assign dirty_cur   = r_dirty[idx];
    assign out_free    = !r_out_valid || !i_stall;
    assign rd_en       = i_cmd.search || i_cmd.rd_slot || i_cmd.flush_step;
    assign rd_addr     = i_cmd.rd_slot ? r_slot : idx;

    // Status toward the controller.
    always_comb begin
        o_status.req_flush   = i_req_type;
        o_status.hit         = r_q_live && (r_tag_q == r_sector);
        o_status.search_done = !r_q_live && !idx_lt_used;
        o_status.full        = full;
        o_status.acc_cur     = r_accessed[idx];
        o_status.dirty_cur   = dirty_cur;
        o_status.dirty_slot  = r_dirty[r_slot];
        o_status.scan_end    = !idx_lt_used ||
                               (r_wbcnt == scc_pkg::WBCNT_W'(scc_pkg::MAX_WB));
        o_status.pend_valid  = r_pend_valid;
        o_status.out_free    = out_free;
    end

    // Tag memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.fill) begin
            r_tag_mem[r_slot] <= r_sector;
        end
        if (rd_en) begin
            r_tag_q <= r_tag_mem[rd_addr];
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sector <= i_sector;
            r_wr     <= i_is_write;
        end
        if (i_cmd.search) begin
            r_q_idx <= idx;
        end
        if (i_cmd.set_hit) begin
            r_slot <= r_q_idx;
        end else if (i_cmd.set_free_slot) begin
            r_slot <= r_used[IDX_W-1:0];
        end else if (i_cmd.victim_take || (i_cmd.flush_step && dirty_cur)) begin
            r_slot <= idx;
        end
        if (i_cmd.pend_load) begin
            r_pend_slot <= r_slot;
            r_pend_tag  <= r_tag_q;
        end
        if (i_cmd.emit) begin
            r_out_action <= em_action;
            r_out_slot   <= em_slot;
            r_out_sector <= em_sector;
            r_out_last   <= em_last;
        end
    end

    // Control registers and per-slot flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used       <= '0;
            r_idx        <= '0;
            r_q_live     <= 1'b0;
            r_wbcnt      <= '0;
            r_pend_valid <= 1'b0;
            r_dirty      <= '0;
            r_accessed   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_q_live    <= i_cmd.search && idx_lt_used;

            if (i_cmd.fill && !full) begin
                r_used <= r_used + 1'b1;
            end

            // Scan index for the tag search, victim sweep and flush walk.
            if (i_cmd.load || i_cmd.victim_start) begin
                r_idx <= '0;
            end else if ((i_cmd.search && idx_lt_used) || i_cmd.flush_step) begin
                r_idx <= r_idx + 1'b1;
            end else if (i_cmd.victim_step) begin
                r_idx <= (r_idx == CNT_W'(SLOT_COUNT - 1)) ? '0 : r_idx + 1'b1;
            end

            if (i_cmd.load) begin
                r_wbcnt <= '0;
            end else if (i_cmd.flush_step && dirty_cur) begin
                r_wbcnt <= r_wbcnt + 1'b1;
            end

            if (i_cmd.load || i_cmd.pend_clear) begin
                r_pend_valid <= 1'b0;
            end else if (i_cmd.pend_load) begin
                r_pend_valid <= 1'b1;
            end

            // Dirty flags.
            if (i_cmd.hit_update && r_wr) begin
                r_dirty[r_slot] <= 1'b1;
            end
            if (i_cmd.fill) begin
                r_dirty[r_slot] <= r_wr;
            end
            if (i_cmd.wb_clean) begin
                r_dirty[r_slot] <= 1'b0;
            end
            if (i_cmd.flush_step && dirty_cur) begin
                r_dirty[idx] <= 1'b0;
            end

            // Accessed flags: set on use, cleared as the sweep passes.
            if (i_cmd.hit_update || i_cmd.fill) begin
                r_accessed[r_slot] <= 1'b1;
            end
            if (i_cmd.victim_step) begin
                r_accessed[idx] <= 1'b0;
            end
        end
    end

    // Output register holds until the receiver takes it.
    always_comb begin
        if (i_cmd.emit) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && i_stall;
        end
    end

    // Fields of the result being emitted.
    always_comb begin
        case (i_cmd.emit_sel)
            scc_pkg::EM_FILL: begin
                em_action = scc_pkg::ACT_FILL;
                em_slot   = r_slot;
                em_sector = r_sector;
                em_last   = 1'b1;
            end
            scc_pkg::EM_VICTIM: begin
                em_action = scc_pkg::ACT_WRITEBACK;
                em_slot   = r_slot;
                em_sector = r_tag_q;
                em_last   = 1'b0;
            end
            scc_pkg::EM_PEND: begin
                em_action = scc_pkg::ACT_WRITEBACK;
                em_slot   = r_pend_slot;
                em_sector = r_pend_tag;
                em_last   = i_cmd.last;
            end
            default: begin
                em_action = scc_pkg::ACT_HIT;
                em_slot   = r_slot;
                em_sector = r_sector;
                em_last   = 1'b1;
            end
        endcase
    end

    // The slot port carries the low bits of the slot index.
    assign slot_ext     = {{scc_pkg::SLOT_W{1'b0}}, r_out_slot};
    assign o_valid      = r_out_valid;
    assign o_action     = r_out_action;
    assign o_slot       = slot_ext[scc_pkg::SLOT_W-1:0];
    assign o_sector_out = r_out_sector;
    assign o_last       = r_out_last;

endmodule

// File: sim/sector_cache_second_chance_test.sv
`timescale 1ns / 1ps

module sector_cache_second_chance_test;

    localparam int SLOTS        = scc_pkg::SLOT_COUNT_DEF;
    localparam int DIR_COUNT    = 18;
    localparam int RANDOM_ITEMS = 212;
    localparam int TOTAL_ITEMS  = DIR_COUNT + RANDOM_ITEMS;
    localparam int POOL_SIZE    = 90;
    localparam int DRAIN_CYCLES = 400;
    localparam int HANG_LIMIT   = 5000;

    // One result item as it leaves the block.
    typedef struct packed {
        logic [scc_pkg::ACTION_W-1:0] action;
        logic [scc_pkg::SLOT_W-1:0]   slot;
        logic [scc_pkg::SECTOR_W-1:0] sector;
        logic                         last;
    } t_cache_result;

    // One row of the directed table; a negative typed count hands the row to the predictor.
    typedef struct {
        logic                         req;
        logic [scc_pkg::SECTOR_W-1:0] sector;
        logic                         wr;
        int                           n_typed;
        t_cache_result                res0;
        t_cache_result                res1;
    } t_dir_row;

    localparam t_cache_result NO_RESULT = '0;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_valid = 1'b0;
    logic                         i_req_type = 1'b0;
    logic [scc_pkg::SECTOR_W-1:0] i_sector = '0;
    logic                         i_is_write = 1'b0;
    logic                         i_stall = 1'b0;
    logic                         o_stall;
    logic                         o_valid;
    logic [scc_pkg::ACTION_W-1:0] o_action;
    logic [scc_pkg::SLOT_W-1:0]   o_slot;
    logic [scc_pkg::SECTOR_W-1:0] o_sector_out;
    logic                         o_last;

    // Directory copy kept by the predictor.
    int                           model_used;
    logic [scc_pkg::SECTOR_W-1:0] model_tags [SLOTS];
    bit                           model_dirty [SLOTS];
    bit                           model_accessed [SLOTS];

    t_cache_result                step_results [$];
    t_cache_result                pending_results [$];
    logic [scc_pkg::SECTOR_W-1:0] sector_pool [POOL_SIZE];
    int                           error_count = 0;
    int                           tx_idle_pct = 0;
    int                           rx_idle_pct = 0;
    int                           hang_cycles = 0;

    // Directed items: reset state, field extremes, hits, flushes with and without dirty slots.
    t_dir_row directed_rows [DIR_COUNT] = '{
        '{1'b1, 32'hDEADBEEF, 1'b1, 0, NO_RESULT, NO_RESULT},
        '{1'b0, 32'h00000000, 1'b0, 1, '{scc_pkg::ACT_FILL, 6'd0, 32'h00000000, 1'b1}, NO_RESULT},
        '{1'b0, 32'hFFFFFFFF, 1'b1, 1, '{scc_pkg::ACT_FILL, 6'd1, 32'hFFFFFFFF, 1'b1}, NO_RESULT},
        '{1'b0, 32'h00000000, 1'b0, 1, '{scc_pkg::ACT_HIT, 6'd0, 32'h00000000, 1'b1}, NO_RESULT},
        '{1'b0, 32'h00000000, 1'b1, 1, '{scc_pkg::ACT_HIT, 6'd0, 32'h00000000, 1'b1}, NO_RESULT},
        '{1'b0, 32'hFFFFFFFF, 1'b0, 1, '{scc_pkg::ACT_HIT, 6'd1, 32'hFFFFFFFF, 1'b1}, NO_RESULT},
        '{1'b1, 32'h00000000, 1'b0, 2, '{scc_pkg::ACT_WRITEBACK, 6'd0, 32'h00000000, 1'b0},
          '{scc_pkg::ACT_WRITEBACK, 6'd1, 32'hFFFFFFFF, 1'b1}},
        '{1'b1, 32'hFFFFFFFF, 1'b1, 0, NO_RESULT, NO_RESULT},
        '{1'b0, 32'h80000000, 1'b1, 1, '{scc_pkg::ACT_FILL, 6'd2, 32'h80000000, 1'b1}, NO_RESULT},
        '{1'b0, 32'h7FFFFFFF, 1'b0, 1, '{scc_pkg::ACT_FILL, 6'd3, 32'h7FFFFFFF, 1'b1}, NO_RESULT},
        '{1'b0, 32'h00000001, 1'b1, 1, '{scc_pkg::ACT_FILL, 6'd4, 32'h00000001, 1'b1}, NO_RESULT},
        '{1'b0, 32'hFFFFFFFE, 1'b0, 1, '{scc_pkg::ACT_FILL, 6'd5, 32'hFFFFFFFE, 1'b1}, NO_RESULT},
        '{1'b0, 32'hFFFFFFFF, 1'b1, 1, '{scc_pkg::ACT_HIT, 6'd1, 32'hFFFFFFFF, 1'b1}, NO_RESULT},
        '{1'b0, 32'h80000000, 1'b0, 1, '{scc_pkg::ACT_HIT, 6'd2, 32'h80000000, 1'b1}, NO_RESULT},
        '{1'b0, 32'h7FFFFFFF, 1'b1, -1, NO_RESULT, NO_RESULT},
        '{1'b1, 32'h12345678, 1'b0, -1, NO_RESULT, NO_RESULT},
        '{1'b1, 32'hA5A5A5A5, 1'b1, -1, NO_RESULT, NO_RESULT},
        '{1'b0, 32'h5A5A5A5A, 1'b1, -1, NO_RESULT, NO_RESULT}
    };

    sector_cache_second_chance dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_req_type   (i_req_type),
        .i_sector     (i_sector),
        .i_is_write   (i_is_write),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_action     (o_action),
        .o_slot       (o_slot),
        .o_sector_out (o_sector_out),
        .o_last       (o_last)
    );

    always #1 i_clk = ~i_clk;

    // Work out the results of one request and update the directory copy.
    task automatic predict_request(input logic req, input logic [scc_pkg::SECTOR_W-1:0] sec,
                                   input logic wr);
        int idx;
        int pass;
        int victim;
        bit found;
        t_cache_result res;
        step_results.delete();
        if (req) begin
            // A flush cleans every dirty filled slot in rising order.
            for (idx = 0; idx < model_used && step_results.size() < scc_pkg::MAX_WB;
                 idx++) begin
                if (model_dirty[idx]) begin
                    step_results.push_back(t_cache_result'{scc_pkg::ACT_WRITEBACK,
                                                           idx[scc_pkg::SLOT_W-1:0],
                                                           model_tags[idx], 1'b0});
                    model_dirty[idx] = 1'b0;
                end
            end
            if (step_results.size() != 0) begin
                res = step_results.pop_back();
                res.last = 1'b1;
                step_results.push_back(res);
            end
            return;
        end
        for (idx = 0; idx < model_used; idx++) begin
            if (model_tags[idx] == sec) begin
                model_accessed[idx] = 1'b1;
                if (wr)
                    model_dirty[idx] = 1'b1;
                step_results.push_back(t_cache_result'{scc_pkg::ACT_HIT,
                                                       idx[scc_pkg::SLOT_W-1:0], sec, 1'b1});
                return;
            end
        end
        victim = 0;
        if (model_used < SLOTS) begin
            victim = model_used;
            model_used++;
        end else begin
            // Second-chance sweep from slot 0; the second pass always finds a victim.
            found = 1'b0;
            for (pass = 0; pass < 2; pass++) begin
                for (idx = 0; idx < SLOTS; idx++) begin
                    if (!found) begin
                        if (model_accessed[idx]) begin
                            model_accessed[idx] = 1'b0;
                        end else begin
                            victim = idx;
                            found = 1'b1;
                        end
                    end
                end
            end
            if (model_dirty[victim]) begin
                step_results.push_back(t_cache_result'{scc_pkg::ACT_WRITEBACK,
                                                       victim[scc_pkg::SLOT_W-1:0],
                                                       model_tags[victim], 1'b0});
                model_dirty[victim] = 1'b0;
            end
        end
        model_tags[victim] = sec;
        model_dirty[victim] = wr;
        model_accessed[victim] = 1'b1;
        step_results.push_back(t_cache_result'{scc_pkg::ACT_FILL,
                                               victim[scc_pkg::SLOT_W-1:0], sec, 1'b1});
    endtask

    // Offer one item, wait for its acceptance, then queue what it should produce.
    task automatic issue_request(input logic req, input logic [scc_pkg::SECTOR_W-1:0] sec,
                                 input logic wr, input int n_typed,
                                 input t_cache_result res0, input t_cache_result res1);
        int k;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req_type <= req;
        i_sector <= sec;
        i_is_write <= wr;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        predict_request(req, sec, wr);
        if (n_typed < 0) begin
            for (k = 0; k < step_results.size(); k++)
                pending_results.push_back(step_results[k]);
        end else begin
            if (n_typed >= 1)
                pending_results.push_back(res0);
            if (n_typed >= 2)
                pending_results.push_back(res1);
        end
    endtask

    // Idle rates per third of the run: sender light, then receiver light, then none.
    task automatic set_idle_phase(input int item_idx);
        case ((item_idx * 3) / TOTAL_ITEMS)
            0: begin
                tx_idle_pct = 23;
                rx_idle_pct = 66;
            end
            1: begin
                tx_idle_pct = 66;
                rx_idle_pct = 23;
            end
            default: begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
        endcase
    endtask

    // Receiver stalls at random.
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        t_cache_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: action %0d slot %0d sector %h last %0d",
                       o_action, o_slot, o_sector_out, o_last);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_action !== want.action) begin
                    $error("action: expected %0d, got %0d", want.action, o_action);
                    error_count++;
                end
                if (o_slot !== want.slot) begin
                    $error("slot: expected %0d, got %0d", want.slot, o_slot);
                    error_count++;
                end
                if (o_sector_out !== want.sector) begin
                    $error("sector_out: expected %h, got %h", want.sector, o_sector_out);
                    error_count++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_last);
                    error_count++;
                end
            end
        end
    end

    // Hang detection: too long without any item moving on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            hang_cycles <= 0;
        else
            hang_cycles <= hang_cycles + 1;
        if (hang_cycles >= HANG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Main sequence: reset, directed table, random traffic, drain.
    initial begin
        int idx;
        int pick;
        logic                         req;
        logic [scc_pkg::SECTOR_W-1:0] sec;
        logic                         wr;
        model_used = 0;
        for (idx = 0; idx < SLOTS; idx++) begin
            model_tags[idx] = '0;
            model_dirty[idx] = 1'b0;
            model_accessed[idx] = 1'b0;
        end
        for (idx = 0; idx < POOL_SIZE; idx++)
            sector_pool[idx] = $urandom;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (idx = 0; idx < DIR_COUNT; idx++) begin
            set_idle_phase(idx);
            issue_request(directed_rows[idx].req, directed_rows[idx].sector,
                          directed_rows[idx].wr, directed_rows[idx].n_typed,
                          directed_rows[idx].res0, directed_rows[idx].res1);
        end

        // Mostly accesses to a pool a bit larger than the cache, so that it fills and
        // then evicts; some fresh sectors and occasional flushes on top.
        for (idx = 0; idx < RANDOM_ITEMS; idx++) begin
            set_idle_phase(DIR_COUNT + idx);
            pick = $urandom_range(99);
            if (pick < 6) begin
                req = 1'b1;
                sec = $urandom;
                wr = 1'($urandom_range(1));
            end else begin
                req = 1'b0;
                sec = (pick < 18) ? $urandom : sector_pool[$urandom_range(POOL_SIZE - 1)];
                wr = ($urandom_range(99) < 40);
            end
            issue_request(req, sec, wr, -1, NO_RESULT, NO_RESULT);
        end
        i_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: files.f
rtl/core/scc_pkg.sv
rtl/core/scc_ctrl.sv
rtl/core/scc_datapath.sv
rtl/core/sector_cache_second_chance.sv
sim/sector_cache_second_chance_test.sv
